### design/pau_pkg.sv
package pau_pkg;

	localparam int DEF_ARCHIVE_DEPTH   = 256;
	localparam int DEF_OBJECTIVE_WIDTH = 32;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_READ   = 2'd1,
		MODE_MARK   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_APPENDED = 3'd0,
		ST_REPLACED = 3'd1,
		ST_REJECTED = 3'd2,
		ST_FULL     = 3'd3,
		ST_READ     = 3'd4,
		ST_BAD_IDX  = 3'd5,
		ST_MARKED   = 3'd6,
		ST_CLEARED  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_WALK,
		S_FINISH,
		S_RD_WAIT,
		S_MARK_WAIT
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic walk_init;
		logic walk;
		logic finish;
		logic rd_issue;
		logic read_out;
		logic mark_wr;
		logic clear;
		logic bad_idx;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  idx_ok;
		logic  walk_done;
	} dp_stat_t;

endpackage

### design/pau_ctl.sv
module pau_ctl import pau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.mode)
					MODE_INSERT: begin
						cmd.walk_init = 1'b1;
						state_d       = S_WALK;
					end
					MODE_READ: begin
						if (stat.idx_ok) begin
							cmd.rd_issue = 1'b1;
							state_d      = S_RD_WAIT;
						end else begin
							cmd.bad_idx = 1'b1;
							state_d     = S_IDLE;
						end
					end
					MODE_MARK: begin
						if (stat.idx_ok) begin
							cmd.rd_issue = 1'b1;
							state_d      = S_MARK_WAIT;
						end else begin
							cmd.bad_idx = 1'b1;
							state_d     = S_IDLE;
						end
					end
					MODE_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
				endcase
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			S_RD_WAIT: begin
				cmd.read_out = 1'b1;
				state_d      = S_IDLE;
			end
			S_MARK_WAIT: begin
				cmd.mark_wr = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### design/pau_dp.sv
module pau_dp import pau_pkg::*; #(
	parameter int ARCHIVE_DEPTH   = DEF_ARCHIVE_DEPTH,
	parameter int OBJECTIVE_WIDTH = DEF_OBJECTIVE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [1:0]  mode,
	input  logic [31:0] new_distance,
	input  logic [31:0] new_cost,
	input  logic [7:0]  entry_index,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] entry_distance,
	output logic [31:0] entry_cost,
	output logic        entry_unexplored,
	output logic [8:0]  entry_count,
	output logic [7:0]  removed_count
);

	localparam int SW    = (OBJECTIVE_WIDTH < 32) ? OBJECTIVE_WIDTH : 32;
	localparam int WW    = 2 * SW + 1;
	localparam int AW    = (ARCHIVE_DEPTH > 2) ? $clog2(ARCHIVE_DEPTH) : 1;
	localparam int OW    = $clog2(ARCHIVE_DEPTH + 1);
	localparam int CW    = (OW > 8) ? OW : 8;
	localparam int EW    = (OW > 9) ? OW : 9;
	localparam logic [OW-1:0] DEPTH = OW'(ARCHIVE_DEPTH);

	logic [WW-1:0] mem [ARCHIVE_DEPTH];

	mode_t         mode_q;
	logic [SW-1:0] nd_q, nc_q;
	logic [7:0]    idx_q;
	logic [OW-1:0] occ_q, r_q, w_q;
	logic          v_s1, chg_q, rej_q;
	logic [7:0]    rem_q;
	logic [WW-1:0] rdata_s1;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr, idx_addr;
	logic [WW-1:0] wr_data;
	logic [CW-1:0] idx_ext;
	logic [SW-1:0] sd, sc;
	logic          proc, keep, beats, dom_by, do_new, do_drop, do_move, do_append;
	logic [OW-1:0] occ_new;
	logic [EW-1:0] cnt_ext;

	logic          done_q, unexp_q;
	status_t       status_q;
	logic [SW-1:0] dist_q, cost_q;
	logic [8:0]    count_q;
	logic [7:0]    removed_q;

	assign idx_ext  = CW'(idx_q);
	assign idx_addr = idx_ext[AW-1:0];
	assign sd       = rdata_s1[SW-1:0];
	assign sc       = rdata_s1[2*SW-1:SW];

	assign stat.mode      = mode_q;
	assign stat.idx_ok    = (idx_ext < CW'(occ_q));
	assign stat.walk_done = (r_q == occ_q) && !v_s1;

	assign dom_by  = (nd_q > sd) && (nc_q > sc);
	assign beats   = (nd_q < sd) && (nc_q < sc);
	assign proc    = cmd.walk && v_s1;
	assign keep    = rej_q || dom_by;
	assign do_new  = proc && !keep && beats && !chg_q;
	assign do_drop = proc && !keep && beats && chg_q;
	assign do_move = proc && !do_new && !do_drop;
	assign do_append = cmd.finish && !rej_q && !chg_q && (w_q < DEPTH);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.walk && (r_q < occ_q)) begin
			rd_en   = 1'b1;
			rd_addr = r_q[AW-1:0];
		end else if (cmd.rd_issue) begin
			rd_en   = 1'b1;
			rd_addr = idx_addr;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = w_q[AW-1:0];
		wr_data = {1'b1, nc_q, nd_q};
		if (do_new || do_append) begin
			wr_en = 1'b1;
		end else if (do_move) begin
			wr_en   = 1'b1;
			wr_data = rdata_s1;
		end else if (cmd.mark_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx_addr;
			wr_data = {1'b0, rdata_s1[2*SW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			nd_q   <= new_distance[SW-1:0];
			nc_q   <= new_cost[SW-1:0];
			idx_q  <= entry_index;
		end
	end

	always_comb begin
		occ_new = w_q;
		if (do_append) begin
			occ_new = w_q + 1'b1;
		end
	end

	assign cnt_ext = EW'(occ_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			r_q   <= '0;
			w_q   <= '0;
			v_s1  <= 1'b0;
			chg_q <= 1'b0;
			rej_q <= 1'b0;
			rem_q <= '0;
		end else begin
			if (cmd.walk_init) begin
				r_q   <= '0;
				w_q   <= '0;
				v_s1  <= 1'b0;
				chg_q <= 1'b0;
				rej_q <= 1'b0;
				rem_q <= '0;
			end else if (cmd.walk) begin
				if (r_q < occ_q) begin
					r_q  <= r_q + 1'b1;
					v_s1 <= 1'b1;
				end else begin
					v_s1 <= 1'b0;
				end
				if (do_new || do_move) begin
					w_q <= w_q + 1'b1;
				end
				if (do_new) begin
					chg_q <= 1'b1;
				end
				if (proc && keep) begin
					rej_q <= 1'b1;
				end
				if (do_drop && (rem_q != 8'hFF)) begin
					rem_q <= rem_q + 8'd1;
				end
			end
			if (cmd.finish) begin
				occ_q <= occ_new;
			end else if (cmd.clear) begin
				occ_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish || cmd.read_out || cmd.mark_wr || cmd.clear || cmd.bad_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish || cmd.read_out || cmd.mark_wr || cmd.clear || cmd.bad_idx) begin
			dist_q    <= '0;
			cost_q    <= '0;
			unexp_q   <= 1'b0;
			removed_q <= '0;
			count_q   <= 9'(CW'(occ_q));
			if (cmd.finish) begin
				removed_q <= rem_q;
				count_q   <= cnt_ext[8:0];
				if (rej_q) begin
					status_q <= ST_REJECTED;
				end else if (chg_q) begin
					status_q <= ST_REPLACED;
				end else if (do_append) begin
					status_q <= ST_APPENDED;
				end else begin
					status_q <= ST_FULL;
				end
			end else if (cmd.read_out) begin
				status_q <= ST_READ;
				dist_q   <= sd;
				cost_q   <= sc;
				unexp_q  <= rdata_s1[2*SW];
			end else if (cmd.mark_wr) begin
				status_q <= ST_MARKED;
			end else if (cmd.clear) begin
				status_q <= ST_CLEARED;
				count_q  <= '0;
			end else begin
				status_q <= ST_BAD_IDX;
			end
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign entry_distance   = 32'(dist_q);
	assign entry_cost       = 32'(cost_q);
	assign entry_unexplored = unexp_q;
	assign entry_count      = count_q;
	assign removed_count    = removed_q;

endmodule

### design/pareto_archive_update_top.sv
// Pareto archive of two-objective points. A word is taken when start is high
// and busy is low; its result is presented for exactly one cycle with done
// high and the receiver cannot stall it, so it must capture the result on
// that cycle. An insert walks the archive through the single memory, one
// entry per cycle, in the states S_DISPATCH, S_WALK and S_FINISH. A read or
// mark passes S_DISPATCH and a wait state; a clear or an out-of-range
// index is settled in S_DISPATCH. A new word may be taken in the cycle its
// predecessor's result is presented.
module pareto_archive_update_top import pau_pkg::*; #(
	parameter int ARCHIVE_DEPTH   = DEF_ARCHIVE_DEPTH,
	parameter int OBJECTIVE_WIDTH = DEF_OBJECTIVE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] new_distance,
	input  logic [31:0] new_cost,
	input  logic [7:0]  entry_index,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] entry_distance,
	output logic [31:0] entry_cost,
	output logic        entry_unexplored,
	output logic [8:0]  entry_count,
	output logic [7:0]  removed_count
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pau_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	pau_dp #(
		.ARCHIVE_DEPTH   (ARCHIVE_DEPTH),
		.OBJECTIVE_WIDTH (OBJECTIVE_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.mode             (mode),
		.new_distance     (new_distance),
		.new_cost         (new_cost),
		.entry_index      (entry_index),
		.done             (done),
		.status           (status),
		.entry_distance   (entry_distance),
		.entry_cost       (entry_cost),
		.entry_unexplored (entry_unexplored),
		.entry_count      (entry_count),
		.removed_count    (removed_count)
	);

endmodule

### tb/sv/pareto_archive_update_top_tb.sv
module pareto_archive_update_top_tb;
	import pau_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = DEF_ARCHIVE_DEPTH;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE      = 270;

	typedef struct packed {
		status_t     stat;
		logic [31:0] distance;
		logic [31:0] cost;
		logic        unexp;
		logic [8:0]  occ;
		logic [7:0]  removed;
	} outcome_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        start        = 1'b0;
	mode_t       mode         = MODE_INSERT;
	logic [31:0] new_distance = '0;
	logic [31:0] new_cost     = '0;
	logic [7:0]  entry_index  = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [31:0] entry_distance;
	logic [31:0] entry_cost;
	logic        entry_unexplored;
	logic [8:0]  entry_count;
	logic [7:0]  removed_count;

	logic [31:0] arc_dist [DEPTH];
	logic [31:0] arc_cost [DEPTH];
	logic        arc_unexp [DEPTH];
	int          arc_occ = 0;

	outcome_t predicted_outcomes [$];
	int       failures    = 0;
	int       idle_pct    = 0;
	int       cycle_count = 0;

	pareto_archive_update_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.new_distance     (new_distance),
		.new_cost         (new_cost),
		.entry_index      (entry_index),
		.done             (done),
		.status           (status),
		.entry_distance   (entry_distance),
		.entry_cost       (entry_cost),
		.entry_unexplored (entry_unexplored),
		.entry_count      (entry_count),
		.removed_count    (removed_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic outcome_t apply_archive_op(mode_t m, logic [31:0] d, logic [31:0] c,
			logic [7:0] idx);
		outcome_t o;
		int       w;
		int       removed;
		bit       replaced;
		bit       rejected;
		o        = '0;
		w        = 0;
		removed  = 0;
		replaced = 1'b0;
		rejected = 1'b0;
		case (m)
			MODE_INSERT: begin
				for (int r = 0; r < arc_occ; r++) begin
					if (d > arc_dist[r] && c > arc_cost[r]) begin
						// dominated: keep the rest in order
						for (int k = r; k < arc_occ; k++) begin
							arc_dist[w]  = arc_dist[k];
							arc_cost[w]  = arc_cost[k];
							arc_unexp[w] = arc_unexp[k];
							w++;
						end
						rejected = 1'b1;
						break;
					end
					if (d < arc_dist[r] && c < arc_cost[r]) begin
						if (!replaced) begin
							arc_dist[w]  = d;
							arc_cost[w]  = c;
							arc_unexp[w] = 1'b1;
							replaced     = 1'b1;
							w++;
						end else begin
							removed++;
						end
					end else begin
						arc_dist[w]  = arc_dist[r];
						arc_cost[w]  = arc_cost[r];
						arc_unexp[w] = arc_unexp[r];
						w++;
					end
				end
				arc_occ = w;
				if (rejected) begin
					o.stat = ST_REJECTED;
				end else if (replaced) begin
					o.stat = ST_REPLACED;
				end else if (arc_occ < DEPTH) begin
					arc_dist[arc_occ]  = d;
					arc_cost[arc_occ]  = c;
					arc_unexp[arc_occ] = 1'b1;
					arc_occ++;
					o.stat = ST_APPENDED;
				end else begin
					o.stat = ST_FULL;
				end
			end
			MODE_READ: begin
				if (idx < arc_occ) begin
					o.distance = arc_dist[idx];
					o.cost     = arc_cost[idx];
					o.unexp    = arc_unexp[idx];
					o.stat     = ST_READ;
				end else begin
					o.stat = ST_BAD_IDX;
				end
			end
			MODE_MARK: begin
				if (idx < arc_occ) begin
					arc_unexp[idx] = 1'b0;
					o.stat         = ST_MARKED;
				end else begin
					o.stat = ST_BAD_IDX;
				end
			end
			default: begin
				arc_occ = 0;
				o.stat  = ST_CLEARED;
			end
		endcase
		o.occ     = arc_occ[8:0];
		o.removed = (removed > 255) ? 8'd255 : removed[7:0];
		return o;
	endfunction

	// called at a falling edge, returns at a falling edge with start still high
	task automatic send_word(mode_t m, logic [31:0] d, logic [31:0] c, logic [7:0] idx);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		mode         <= m;
		new_distance <= d;
		new_cost     <= c;
		entry_index  <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted_outcomes = {predicted_outcomes, apply_archive_op(m, d, c, idx)};
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (predicted_outcomes.size() != 0);
	endtask

	task automatic test_empty_archive();
		idle_pct = 30;
		send_word(MODE_READ, 32'd0, 32'd0, 8'd0);
		send_word(MODE_MARK, 32'd0, 32'd0, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd255);
		send_word(MODE_CLEAR, 32'd0, 32'd0, 8'd0);
		wait_drained();
	endtask

	task automatic test_basic_ops();
		idle_pct = 30;
		send_word(MODE_INSERT, 32'd100, 32'd100, 8'd0);
		send_word(MODE_INSERT, 32'd100, 32'd100, 8'd0);
		send_word(MODE_INSERT, 32'd200, 32'd200, 8'd0);
		send_word(MODE_INSERT, 32'd50, 32'd150, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd2);
		send_word(MODE_MARK, 32'd0, 32'd0, 8'd1);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd1);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd3);
		send_word(MODE_INSERT, 32'd10, 32'd10, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd0);
		send_word(MODE_INSERT, 32'hFFFF_FFFF, 32'd0, 8'd0);
		send_word(MODE_INSERT, 32'd0, 32'hFFFF_FFFF, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd1);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd2);
		send_word(MODE_INSERT, 32'd0, 32'd0, 8'd0);
		send_word(MODE_MARK, 32'd0, 32'd0, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd0);
		send_word(MODE_MARK, 32'd0, 32'd0, 8'd1);
		send_word(MODE_CLEAR, 32'd0, 32'd0, 8'd0);
		wait_drained();
	endtask

	// fill with a staircase, overflow it, then sweep it with one point
	task automatic test_full_archive();
		idle_pct = 0;
		for (int i = 0; i < DEPTH; i++) begin
			send_word(MODE_INSERT, 32'(i + 1), 32'(DEPTH - i), 8'd0);
		end
		send_word(MODE_INSERT, 32'd300, 32'd0, 8'd0);
		send_word(MODE_INSERT, 32'd2, 32'd300, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd255);
		send_word(MODE_MARK, 32'd0, 32'd0, 8'd255);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd255);
		send_word(MODE_INSERT, 32'd0, 32'd0, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd0);
		send_word(MODE_READ, 32'd0, 32'd0, 8'd1);
		send_word(MODE_CLEAR, 32'd0, 32'd0, 8'd0);
		wait_drained();
	endtask

	task automatic test_random_traffic(int n_words, int idle);
		int          sel;
		int          t;
		mode_t       m;
		logic [31:0] d;
		logic [31:0] c;
		logic [7:0]  idx;
		idle_pct = idle;
		repeat (n_words) begin
			sel = $urandom_range(0, 99);
			m   = (sel < 60) ? MODE_INSERT : (sel < 80) ? MODE_READ :
				(sel < 95) ? MODE_MARK : MODE_CLEAR;
			d   = $urandom;
			c   = $urandom;
			if (arc_occ != 0 && $urandom_range(0, 99) < 85)
				idx = 8'($urandom_range(0, arc_occ - 1));
			else
				idx = 8'($urandom_range(0, 255));
			if (m == MODE_INSERT) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) begin
					// near a front: mostly incomparable, some domination
					t = $urandom_range(0, 31);
					d = 32'(t * 8 + $urandom_range(0, 12));
					c = 32'((31 - t) * 8 + $urandom_range(0, 12));
				end else if (sel < 8) begin
					d = $urandom_range(0, 255);
					c = $urandom_range(0, 255);
				end else if (sel == 9) begin
					d = $urandom_range(0, 40);
					c = $urandom_range(0, 40);
				end
			end
			send_word(m, d, c, idx);
		end
		wait_drained();
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			if (predicted_outcomes.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result word: status %0d count %0d",
						status, entry_count);
			end else begin
				want = predicted_outcomes.pop_front();
				if (status !== want.stat || entry_distance !== want.distance ||
						entry_cost !== want.cost || entry_unexplored !== want.unexp ||
						entry_count !== want.occ || removed_count !== want.removed) begin
					failures++;
					if (failures <= 10) begin
						$display("mismatch expected: status %0d dist %h cost %h unexp %b count %0d removed %0d",
							want.stat, want.distance, want.cost, want.unexp, want.occ,
							want.removed);
						$display("         actual:   status %0d dist %h cost %h unexp %b count %0d removed %0d",
							status, entry_distance, entry_cost, entry_unexplored,
							entry_count, removed_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_archive();
		test_basic_ops();
		test_full_archive();
		test_random_traffic(200, 0);
		test_random_traffic(200, 70);
		test_random_traffic(200, 7);
		repeat (SETTLE) @(negedge clk);
		if (predicted_outcomes.size() != 0)
			failures++;
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
design/pau_pkg.sv
design/pau_ctl.sv
design/pau_dp.sv
design/pareto_archive_update_top.sv
tb/sv/pareto_archive_update_top_tb.sv
